[sv/dqr_pkg.sv]
// Package for the double-ended queue ring core: sizes, codes and types.
// Used by dqr_store and double_ended_queue_ring_core; depends on nothing.
`default_nettype none

package dqr_pkg;

    // Number of words the ring holds, and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Command codes on the op port.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_REV   = 3'd5
    } dqr_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } dqr_status_t;

    // Control states: idle and accepting, or streaming a listing.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } dqr_state_t;

    // One access to the ring store: a write or a read at one address.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } dqr_req_t;

    // Ring index arithmetic with wrap-around.
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1))
            r = '0;
        else
            r = i + IDX_W'(1);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0)
            r = IDX_W'(DEPTH - 1);
        else
            r = i - IDX_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/double_ended_queue_ring_core.sv]
// Double-ended queue ring core: a bounded deque of signed words.
// How the block is used:
//   A command (op, value) is taken at a rising edge where start is high and
//   busy is low. Each result word appears on word, status and last for one
//   cycle with done high; the receiver takes it there and cannot hold it off.
//   Push front/back, pop front/back and unknown codes give one result, on the
//   cycle after the command is taken, and leave busy low, so such commands
//   can follow one per cycle.
//   A listing of N held words gives N results, the first in the cycle after
//   the command, with last set on the final word; busy is high while the rest
//   stream out, because the single store port reads one entry a cycle. A
//   listing or pop on an empty queue, or a push on a full queue, gives one
//   result with an error status.
//   Reset (rst_n low, asynchronous) empties the queue; the store itself is
//   not cleared, since only held entries are ever read.
// Depends on dqr_pkg and dqr_store.
`default_nettype none

module double_ended_queue_ring_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    op,
    input  wire logic signed [dqr_pkg::WORD_W-1:0] value,
    output logic                               done,
    output logic signed [dqr_pkg::WORD_W-1:0]  word,
    output logic [1:0]                         status,
    output logic                               last
);
    import dqr_pkg::*;

    dqr_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              rev_reg, rev_next;
    logic              done_reg, done_next;
    dqr_status_t       status_reg, status_next;
    logic              last_reg, last_next;
    logic              sel_reg, sel_next;
    dqr_req_t          req;
    logic [WORD_W-1:0] rdata;
    dqr_op_t           op_e;

    assign op_e = dqr_op_t'(op);

    // The word store.
    dqr_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            remain_reg <= '0;
            rev_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            remain_reg <= remain_next;
            rev_reg    <= rev_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            sel_reg    <= sel_next;
        end
    end

    // Command decode, index update and store access.
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        rev_next    = rev_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        last_next   = 1'b1;
        sel_next    = 1'b0;
        req         = '0;
        req.wdata   = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (op_e) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                req.wr_en = 1'b1;
                                if (count_reg == '0)
                                begin
                                    // First word: both ends name the same entry.
                                    back_next = front_reg;
                                    req.addr  = front_reg;
                                end
                                else if (op_e == OP_PUSH_FRONT)
                                begin
                                    front_next = idx_prev(front_reg);
                                    req.addr   = idx_prev(front_reg);
                                end
                                else
                                begin
                                    back_next = idx_next(back_reg);
                                    req.addr  = idx_next(back_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The read is captured at this edge, so the
                                // indices move on at once.
                                req.rd_en = 1'b1;
                                sel_next  = 1'b1;
                                if (op_e == OP_POP_FRONT)
                                begin
                                    req.addr = front_reg;
                                    if (count_reg > CNT_W'(1))
                                        front_next = idx_next(front_reg);
                                end
                                else
                                begin
                                    req.addr = back_reg;
                                    if (count_reg > CNT_W'(1))
                                        back_next = idx_prev(back_reg);
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_LIST_FWD, OP_LIST_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                sel_next    = 1'b1;
                                rev_next    = (op_e == OP_LIST_REV);
                                remain_next = count_reg - CNT_W'(1);
                                last_next   = (count_reg == CNT_W'(1));
                                if (op_e == OP_LIST_REV)
                                begin
                                    req.addr = back_reg;
                                    ptr_next = idx_prev(back_reg);
                                end
                                else
                                begin
                                    req.addr = front_reg;
                                    ptr_next = idx_next(front_reg);
                                end
                                if (count_reg != CNT_W'(1))
                                    state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // Unused codes give a plain acknowledgement.
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // Stream the remaining words, one store read a cycle.
                req.rd_en   = 1'b1;
                req.addr    = ptr_reg;
                ptr_next    = rev_reg ? idx_prev(ptr_reg) : idx_next(ptr_reg);
                remain_next = remain_reg - CNT_W'(1);
                done_next   = 1'b1;
                sel_next    = 1'b1;
                last_next   = (remain_reg == CNT_W'(1));
                if (remain_reg == CNT_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result ports.
    assign busy   = (state_reg == S_LIST);
    assign done   = done_reg;
    assign word   = sel_reg ? signed'(rdata) : '0;
    assign status = status_reg;
    assign last   = last_reg;

endmodule

`default_nettype wire

[sv/dqr_store.sv]
// Ring store of the double-ended queue: one port, write or read per cycle.
// The read data is registered, so it appears in the cycle after the request.
// Depends on dqr_pkg.
`default_nettype none

module dqr_store (
    input  wire logic                     clk,
    input  wire dqr_pkg::dqr_req_t        req,
    output logic [dqr_pkg::WORD_W-1:0]    rdata
);
    import dqr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Synchronous write and registered read through the same address.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[tb/tb_double_ended_queue_ring_core.sv]
// Self-checking testbench for double_ended_queue_ring_core: directed table, then random traffic.
// Each command word is predicted by a model of the ring held here; needs only dqr_pkg and the core.
`timescale 1ns / 100ps

module tb_double_ended_queue_ring_core;

    import dqr_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 7;
    localparam int          RANDOM_ITEMS  = 410;
    localparam int          PHASE_ITEMS   = 40;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PRINT_LIMIT   = 60;
    localparam logic [2:0]  OP_RESERVED_6 = 3'd6;
    localparam logic [2:0]  OP_RESERVED_7 = 3'd7;

    // One result word as the core should present it.
    typedef struct {
        logic [WORD_W-1:0] word;
        dqr_status_t       status;
        logic              last;
    } deque_result_t;

    // One row of the directed table; reps repeats the command with value counting up.
    typedef struct {
        logic [2:0]        op;
        logic [WORD_W-1:0] value;
        int                reps;
        bit                typed;
        deque_result_t     res;
    } stim_row_t;

    logic                     clk   = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               op    = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic                     last;

    // Model of the ring, and the result words it still owes.
    logic [WORD_W-1:0] ring_copy [DEPTH];
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [CNT_W-1:0]  held_count;
    deque_result_t     owed_words [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Directed table: empty errors, spare codes, single-word edge, fill to full, drain.
    stim_row_t directed_rows [] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 1'b1}},
        '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 1'b1}},
        '{OP_LIST_FWD,   32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 1'b1}},
        '{OP_LIST_REV,   32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 1'b1}},
        '{OP_RESERVED_6, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0, ST_OK,    1'b1}},
        '{OP_RESERVED_7, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0, ST_OK,    1'b1}},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, '{32'h0, ST_OK,    1'b1}},
        '{OP_LIST_REV,   32'h0000_0000, 1,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{32'h7FFF_FFFF, ST_OK, 1'b1}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, '{32'h0, ST_OK,    1'b1}},
        '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{32'h8000_0000, ST_OK, 1'b1}},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_PUSH_BACK,  32'h0000_0000, 1,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_PUSH_FRONT, 32'h0000_0100, 7,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_PUSH_BACK,  32'h5555_5555, 7,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_PUSH_FRONT, 32'h0000_1234, 1,  1'b1, '{32'h0, ST_FULL,  1'b1}},
        '{OP_PUSH_BACK,  32'hAAAA_AAAA, 1,  1'b1, '{32'h0, ST_FULL,  1'b1}},
        '{OP_LIST_FWD,   32'h0000_0000, 1,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_LIST_REV,   32'h0000_0000, 1,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_POP_FRONT,  32'h0000_0000, 2,  1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_POP_BACK,   32'h0000_0000, 14, 1'b0, '{32'h0, ST_OK,    1'b1}},
        '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 1'b1}}
    };

    double_ended_queue_ring_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .op     (op),
        .value  (value),
        .done   (done),
        .word   (word),
        .status (status),
        .last   (last)
    );

    // Clock.
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Ring index steps, wrapping at the store depth.
    function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + 1) % DEPTH);
    endfunction

    function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + DEPTH - 1) % DEPTH);
    endfunction

    // Appends one owed result word.
    task automatic owe_word(input logic [WORD_W-1:0] w, input dqr_status_t st,
                            input logic lst);
        deque_result_t r;
        r.word   = w;
        r.status = st;
        r.last   = lst;
        owed_words.push_back(r);
    endtask

    // Applies one accepted command to the model ring and queues its result words.
    task automatic predict_deque_op(input logic [2:0] c_op, input logic [WORD_W-1:0] c_val);
        logic [IDX_W-1:0] p;
        int               k;
        case (c_op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held_count == CNT_W'(DEPTH))
                begin
                    owe_word('0, ST_FULL, 1'b1);
                end
                else
                begin
                    // A push on an empty ring lands at the front and both ends name it.
                    if (held_count == '0)
                    begin
                        tail_idx = head_idx;
                        ring_copy[head_idx] = c_val;
                    end
                    else if (c_op == OP_PUSH_FRONT)
                    begin
                        head_idx = ring_back(head_idx);
                        ring_copy[head_idx] = c_val;
                    end
                    else
                    begin
                        tail_idx = ring_fwd(tail_idx);
                        ring_copy[tail_idx] = c_val;
                    end
                    held_count = held_count + CNT_W'(1);
                    owe_word('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (held_count == '0)
                begin
                    owe_word('0, ST_EMPTY, 1'b1);
                end
                else if (c_op == OP_POP_FRONT)
                begin
                    owe_word(ring_copy[head_idx], ST_OK, 1'b1);
                    // The indices stay put when the last word leaves.
                    if (held_count > CNT_W'(1)) head_idx = ring_fwd(head_idx);
                    held_count = held_count - CNT_W'(1);
                end
                else
                begin
                    owe_word(ring_copy[tail_idx], ST_OK, 1'b1);
                    if (held_count > CNT_W'(1)) tail_idx = ring_back(tail_idx);
                    held_count = held_count - CNT_W'(1);
                end
            end
            OP_LIST_FWD, OP_LIST_REV:
            begin
                if (held_count == '0)
                begin
                    owe_word('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    p = (c_op == OP_LIST_FWD) ? head_idx : tail_idx;
                    for (k = 0; k < int'(held_count); k++)
                    begin
                        owe_word(ring_copy[p], ST_OK, (k + 1 == int'(held_count)));
                        p = (c_op == OP_LIST_FWD) ? ring_fwd(p) : ring_back(p);
                    end
                end
            end
            default:
            begin
                owe_word('0, ST_OK, 1'b1);
            end
        endcase
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] expd,
                                   input logic [WORD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, expd, got);
    endtask

    // Presents one command word and holds it until the core takes it.
    task automatic send_command(input logic [2:0] c_op, input logic [WORD_W-1:0] c_val,
                                input bit typed, input deque_result_t typed_res);
        op    <= c_op;
        value <= c_val;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_deque_op(c_op, c_val);
        // Where the table types the answer, it stands in for the predicted one.
        if (typed)
        begin
            void'(owed_words.pop_back());
            owed_words.push_back(typed_res);
        end
    endtask

    // Lowers start between command words for a gap of length n; a gap of zero leaves start high.
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Random payload, leaning on the signed extremes now and then.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result checker: each strobed result word against the oldest owed one.
    always @(posedge clk)
    begin
        deque_result_t head;
        if (rst_n && done)
        begin
            if (owed_words.size() == 0)
            begin
                report_mismatch("unexpected result word", '0, word);
            end
            else
            begin
                head = owed_words.pop_front();
                if (word !== head.word)
                    report_mismatch("word", head.word, word);
                if (status !== head.status)
                    report_mismatch("status", WORD_W'(head.status), WORD_W'(status));
                if (last !== head.last)
                    report_mismatch("last", WORD_W'(head.last), WORD_W'(last));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_double_ended_queue_ring_core: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int            row;
        int            k;
        int            sent;
        int            bias;
        int            phase_left;
        bit            quiet;
        int            r;
        logic [2:0]    rop;
        deque_result_t none;

        none.word   = '0;
        none.status = ST_OK;
        none.last   = 1'b1;
        head_idx    = '0;
        tail_idx    = '0;
        held_count  = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (row = 0; row < directed_rows.size(); row++)
        begin
            for (k = 0; k < directed_rows[row].reps; k++)
            begin
                send_command(directed_rows[row].op, directed_rows[row].value + k,
                             directed_rows[row].typed, directed_rows[row].res);
                idle_gap(pick_gap(1'b0));
            end
        end

        // Random traffic in phases that push the fill level up, hold it, or drain it.
        sent       = 0;
        phase_left = 0;
        bias       = 85;
        quiet      = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                phase_left = PHASE_ITEMS;
                case ($urandom_range(0, 2))
                    0:       bias = 85;
                    1:       bias = 50;
                    default: bias = 15;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                rop = $urandom_range(0, 1) ? OP_RESERVED_7 : OP_RESERVED_6;
            else if (r < 12)
                rop = $urandom_range(0, 1) ? OP_LIST_REV : OP_LIST_FWD;
            else if ($urandom_range(0, 99) < bias)
                rop = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                rop = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            send_command(rop, pick_value(), 1'b0, none);
            // Spare codes are merely acknowledged, so they do not count towards the total.
            if (rop != OP_RESERVED_6 && rop != OP_RESERVED_7)
            begin
                sent++;
                phase_left--;
            end
            idle_gap(pick_gap(quiet));
        end

        start <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_double_ended_queue_ring_core: PASS");
        else
            $display("tb_double_ended_queue_ring_core: FAIL");
        $finish;
    end

endmodule
